// File: hdl/i2ra_pkg.sv
// Shared types, constants and digit encoding for the radix ASCII converter.
package i2ra_pkg;

    localparam int VALUE_W    = 64;
    localparam int RADIX_W    = 6;
    localparam int DIGIT_W    = 6;
    localparam int CHAR_W     = 7;
    localparam int STEPS      = 8;
    localparam int CHUNKS     = VALUE_W / STEPS;
    localparam int CHUNK_W    = $clog2(CHUNKS);
    localparam int QUEUE_DEPTH = 2;

    localparam logic [RADIX_W-1:0] RADIX_MIN   = 6'd2;
    localparam logic [RADIX_W-1:0] RADIX_MAX   = 6'd36;
    localparam logic [RADIX_W-1:0] RADIX_RESET = 6'd10;

    localparam logic [DIGIT_W-1:0] DEC_BASE    = 6'd10;
    localparam logic [CHAR_W-1:0]  ASCII_ZERO  = 7'h30;
    localparam logic [CHAR_W-1:0]  ASCII_LC_A  = 7'h61;

    typedef struct packed {
        logic [VALUE_W-1:0] mag;
        logic               neg;
    } t_job;

    function automatic logic [CHAR_W-1:0] to_ascii(input logic [DIGIT_W-1:0] d);
        logic [CHAR_W-1:0] d_ext;
        d_ext = {1'b0, d};
        if (d < DEC_BASE) begin
            return ASCII_ZERO + d_ext;
        end else begin
            return ASCII_LC_A + d_ext - {1'b0, DEC_BASE};
        end
    endfunction

endpackage

// File: hdl/i2ra_front.sv
// Front end: radix register, request intake and sign classification.
module i2ra_front (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_radix_we,
    input  logic [i2ra_pkg::RADIX_W-1:0]        i_radix,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic [i2ra_pkg::VALUE_W-1:0]        i_value,
    input  logic                                i_is_signed,
    input  logic                                i_q_full,
    output logic                                o_push,
    output i2ra_pkg::t_job                      o_job,
    output logic [i2ra_pkg::RADIX_W-1:0]        o_radix
);

    logic [i2ra_pkg::RADIX_W-1:0] r_radix;
    logic [i2ra_pkg::RADIX_W-1:0] n_radix;
    logic                         w_neg;

    always_comb begin
        if (i_radix < i2ra_pkg::RADIX_MIN) begin
            n_radix = i2ra_pkg::RADIX_MIN;
        end else if (i_radix > i2ra_pkg::RADIX_MAX) begin
            n_radix = i2ra_pkg::RADIX_MAX;
        end else begin
            n_radix = i_radix;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radix <= i2ra_pkg::RADIX_RESET;
        end else if (i_radix_we) begin
            r_radix <= n_radix;
        end
    end

    assign w_neg     = i_is_signed & i_value[i2ra_pkg::VALUE_W-1];
    assign o_job.neg = w_neg;
    assign o_job.mag = w_neg ? (~i_value + 1'b1) : i_value;

    assign o_in_stall = i_q_full;
    assign o_push     = i_in_valid & ~i_q_full;
    assign o_radix    = r_radix;

endmodule

// File: hdl/i2ra_queue.sv
// Short request queue between the front end and the conversion engine.
module i2ra_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  i2ra_pkg::t_job i_job,
    output logic           o_full,
    input  logic           i_pop,
    output logic           o_valid,
    output i2ra_pkg::t_job o_job
);

    localparam int PW = (i2ra_pkg::QUEUE_DEPTH > 1) ? $clog2(i2ra_pkg::QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(i2ra_pkg::QUEUE_DEPTH + 1);

    i2ra_pkg::t_job r_ent [i2ra_pkg::QUEUE_DEPTH];
    logic [PW-1:0]  r_wp;
    logic [PW-1:0]  r_rp;
    logic [CW-1:0]  r_cnt;
    logic           w_push;
    logic           w_pop;

    assign o_full  = (r_cnt == CW'(i2ra_pkg::QUEUE_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_job   = r_ent[r_rp];
    assign w_push  = i_push & ~o_full;
    assign w_pop   = i_pop & o_valid;

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_ent[r_wp] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_push) begin
                r_wp <= (r_wp == PW'(i2ra_pkg::QUEUE_DEPTH - 1)) ? '0 : r_wp + 1'b1;
            end
            if (w_pop) begin
                r_rp <= (r_rp == PW'(i2ra_pkg::QUEUE_DEPTH - 1)) ? '0 : r_rp + 1'b1;
            end
            if (w_push && !w_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (!w_push && w_pop) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

// File: hdl/i2ra_back.sv
// Conversion engine: repeated division by the radix, digit store and digit output.
module i2ra_back #(
    parameter int MAX_DIGITS = 64
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic [i2ra_pkg::RADIX_W-1:0]      i_radix,
    input  logic                              i_job_valid,
    input  i2ra_pkg::t_job                    i_job,
    output logic                              o_job_pop,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic [i2ra_pkg::CHAR_W-1:0]       o_digit_char,
    output logic                              o_minus_before,
    output logic                              o_last_digit
);

    localparam int IW = $clog2(MAX_DIGITS);
    localparam int CW = $clog2(MAX_DIGITS + 1);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_DIV  = 2'd1;
    localparam logic [1:0] S_RD   = 2'd2;
    localparam logic [1:0] S_PUT  = 2'd3;

    logic [1:0]                          r_state;
    logic [i2ra_pkg::VALUE_W-1:0]        r_div;
    logic [i2ra_pkg::VALUE_W-1:0]        n_div;
    logic [i2ra_pkg::DIGIT_W-1:0]        r_rem;
    logic [i2ra_pkg::DIGIT_W-1:0]        n_rem;
    logic [i2ra_pkg::DIGIT_W:0]          w_trial;
    logic [i2ra_pkg::CHUNK_W-1:0]        r_chunk;
    logic [CW-1:0]                       r_cnt;
    logic [CW-1:0]                       n_cnt;
    logic [IW-1:0]                       r_ptr;
    logic                                r_neg;
    logic                                r_first;
    logic [i2ra_pkg::DIGIT_W-1:0]        r_rd_data;
    logic [i2ra_pkg::DIGIT_W-1:0]        r_store [MAX_DIGITS];
    logic                                w_digit_done;
    logic                                w_room;
    logic                                w_we;
    logic                                w_slot_free;
    logic                                w_put;
    logic                                r_o_valid;
    logic [i2ra_pkg::CHAR_W-1:0]         r_o_char;
    logic                                r_o_minus;
    logic                                r_o_last;

    always_comb begin
        n_rem   = r_rem;
        n_div   = r_div;
        w_trial = '0;
        for (int i = 0; i < i2ra_pkg::STEPS; i++) begin
            w_trial = {n_rem, n_div[i2ra_pkg::VALUE_W-1]};
            n_div   = {n_div[i2ra_pkg::VALUE_W-2:0], 1'b0};
            if (w_trial >= {1'b0, i_radix}) begin
                n_rem    = i2ra_pkg::DIGIT_W'(w_trial - {1'b0, i_radix});
                n_div[0] = 1'b1;
            end else begin
                n_rem = w_trial[i2ra_pkg::DIGIT_W-1:0];
            end
        end
    end

    assign w_digit_done = (r_state == S_DIV) &&
                          (r_chunk == i2ra_pkg::CHUNK_W'(i2ra_pkg::CHUNKS - 1));
    assign w_room       = (r_cnt < CW'(MAX_DIGITS));
    assign w_we         = w_digit_done & w_room;
    assign n_cnt        = w_room ? r_cnt + 1'b1 : r_cnt;
    assign w_slot_free  = ~r_o_valid | ~i_out_stall;
    assign w_put        = (r_state == S_PUT) & w_slot_free;
    assign o_job_pop    = (r_state == S_IDLE) & i_job_valid;

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_store[r_cnt[IW-1:0]] <= n_rem;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_data <= r_store[r_ptr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_o_valid <= 1'b0;
        end else begin
            if (r_o_valid && !i_out_stall && !w_put) begin
                r_o_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_job_valid) begin
                        r_div   <= i_job.mag;
                        r_neg   <= i_job.neg;
                        r_rem   <= '0;
                        r_chunk <= '0;
                        r_cnt   <= '0;
                        r_first <= 1'b1;
                        r_state <= S_DIV;
                    end
                end
                S_DIV: begin
                    r_div   <= n_div;
                    r_chunk <= r_chunk + 1'b1;
                    if (w_digit_done) begin
                        r_rem <= '0;
                        r_cnt <= n_cnt;
                        if (n_div == '0) begin
                            r_ptr   <= IW'(n_cnt - 1'b1);
                            r_state <= S_RD;
                        end
                    end else begin
                        r_rem <= n_rem;
                    end
                end
                S_RD: begin
                    r_state <= S_PUT;
                end
                S_PUT: begin
                    if (w_slot_free) begin
                        r_o_valid <= 1'b1;
                        r_o_char  <= i2ra_pkg::to_ascii(r_rd_data);
                        r_o_minus <= r_first & r_neg;
                        r_o_last  <= (r_ptr == '0);
                        r_first   <= 1'b0;
                        if (r_ptr == '0) begin
                            r_state <= S_IDLE;
                        end else begin
                            r_ptr   <= r_ptr - 1'b1;
                            r_state <= S_RD;
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_out_valid    = r_o_valid;
    assign o_digit_char   = r_o_char;
    assign o_minus_before = r_o_minus;
    assign o_last_digit   = r_o_last;

endmodule

// File: hdl/integer_to_radix_ascii_core.sv
// Top level of the 64-bit integer to radix ASCII digit converter.
// Input channel: i_in_valid/o_in_stall carry a request of i_value and i_is_signed;
// a request is taken at a rising edge with i_in_valid high and o_in_stall low.
// Output channel: o_out_valid/i_out_stall carry one digit per transfer, most
// significant first, as o_digit_char with o_minus_before on the first digit of a
// negative number and o_last_digit on the final one.
// The radix register is written with i_radix_we/i_radix; the user must do so only
// while the block is idle, which the block does not enforce. Values outside 2 to
// 36 are clamped, and reset sets it to 10. An idle engine takes a request from
// the queue, then the divider makes a pass over the whole value for each digit,
// retiring 8 quotient bits per cycle against a 6-bit remainder. Once the quotient
// is zero, each digit in turn is read from the digit store and loaded into the
// output register; the first digit is offered once all digits are divided out.
// A two-entry request queue lets the input side keep accepting while a number is
// being converted. A stalled output holds its digit and pauses the digit readout.
// Reset is synchronous and active low; it empties the queue and the output
// register and returns the engine to idle. Only the MAX_DIGITS least significant
// digits of a number are kept and emitted.
module integer_to_radix_ascii_core #(
    parameter int MAX_DIGITS = 64
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_radix_we,
    input  logic [i2ra_pkg::RADIX_W-1:0]  i_radix,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic [i2ra_pkg::VALUE_W-1:0]  i_value,
    input  logic                          i_is_signed,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic [i2ra_pkg::CHAR_W-1:0]   o_digit_char,
    output logic                          o_minus_before,
    output logic                          o_last_digit
);

    logic                         w_push;
    logic                         w_q_full;
    logic                         w_q_valid;
    logic                         w_pop;
    i2ra_pkg::t_job               w_in_job;
    i2ra_pkg::t_job               w_q_job;
    logic [i2ra_pkg::RADIX_W-1:0] w_radix;

    i2ra_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_radix_we  (i_radix_we),
        .i_radix     (i_radix),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_value     (i_value),
        .i_is_signed (i_is_signed),
        .i_q_full    (w_q_full),
        .o_push      (w_push),
        .o_job       (w_in_job),
        .o_radix     (w_radix)
    );

    i2ra_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_job   (w_in_job),
        .o_full  (w_q_full),
        .i_pop   (w_pop),
        .o_valid (w_q_valid),
        .o_job   (w_q_job)
    );

    i2ra_back #(
        .MAX_DIGITS (MAX_DIGITS)
    ) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_radix        (w_radix),
        .i_job_valid    (w_q_valid),
        .i_job          (w_q_job),
        .o_job_pop      (w_pop),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_digit_char   (o_digit_char),
        .o_minus_before (o_minus_before),
        .o_last_digit   (o_last_digit)
    );

    a_radix_range : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_radix >= i2ra_pkg::RADIX_MIN) && (w_radix <= i2ra_pkg::RADIX_MAX))
        else $error("radix register left the range 2 to 36");

    a_digit_code : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |->
            ((o_digit_char >= 7'h30) && (o_digit_char <= 7'h39)) ||
            ((o_digit_char >= 7'h61) && (o_digit_char <= 7'h7a)))
        else $error("digit character outside 0-9 and a-z");

    a_gap_after_last : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_stall && o_last_digit) |=> !o_out_valid)
        else $error("digit issued right after the last digit of a number");

    a_pop_with_data : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |-> w_q_valid)
        else $error("engine took a request from an empty queue");

endmodule

// File: verif/integer_to_radix_ascii_core_tb.sv
// Self-checking testbench for the integer to radix ASCII converter core.
`timescale 1ns / 100ps

module integer_to_radix_ascii_core_tb;

    typedef struct {
        logic [i2ra_pkg::CHAR_W-1:0] ch;
        bit                          minus;
        bit                          last;
    } t_digit;

    typedef struct {
        bit                           wr;
        logic [i2ra_pkg::RADIX_W-1:0] wr_val;
        logic [i2ra_pkg::VALUE_W-1:0] value;
        bit                           sgn;
        bit                           typed;
        bit                           minus;
    } t_row;

    localparam logic [i2ra_pkg::VALUE_W-1:0] ALL_ONES = 64'hFFFF_FFFF_FFFF_FFFF;
    localparam logic [i2ra_pkg::VALUE_W-1:0] MOST_NEG = 64'h8000_0000_0000_0000;
    localparam logic [i2ra_pkg::VALUE_W-1:0] MOST_POS = 64'h7FFF_FFFF_FFFF_FFFF;

    logic                          i_clk;
    logic                          i_rst_n;
    logic                          i_radix_we;
    logic [i2ra_pkg::RADIX_W-1:0]  i_radix;
    logic                          i_in_valid;
    logic                          o_in_stall;
    logic [i2ra_pkg::VALUE_W-1:0]  i_value;
    logic                          i_is_signed;
    logic                          o_out_valid;
    logic                          i_out_stall;
    logic [i2ra_pkg::CHAR_W-1:0]   o_digit_char;
    logic                          o_minus_before;
    logic                          o_last_digit;

    t_digit                        digit_q[$];
    t_row                          rows[$];
    string                         row_text[$];
    logic [i2ra_pkg::RADIX_W-1:0]  radix_now;
    bit                            quiet;
    int                            hold_left;
    int                            n_errors;
    int                            n_requests;
    int                            n_digits;
    int                            n_radix_writes;

    integer_to_radix_ascii_core dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_radix_we     (i_radix_we),
        .i_radix        (i_radix),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_value        (i_value),
        .i_is_signed    (i_is_signed),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_digit_char   (o_digit_char),
        .o_minus_before (o_minus_before),
        .o_last_digit   (o_last_digit)
    );

    initial begin
        i_clk = 1'b0;
    end

    always #10 i_clk = ~i_clk;

    function automatic void predict_digits(input logic [i2ra_pkg::VALUE_W-1:0] value,
                                           input bit sgn);
        logic [i2ra_pkg::DIGIT_W-1:0] vals[64];
        logic [i2ra_pkg::VALUE_W-1:0] quo;
        logic [i2ra_pkg::VALUE_W-1:0] base;
        logic [i2ra_pkg::DIGIT_W-1:0] d;
        bit                           neg;
        int                           n;
        t_digit                       e;
        neg  = sgn && value[i2ra_pkg::VALUE_W-1];
        quo  = neg ? (~value + 64'd1) : value;
        base = {{(i2ra_pkg::VALUE_W-i2ra_pkg::RADIX_W){1'b0}}, radix_now};
        n    = 0;
        do begin
            if (n < 64) begin
                vals[n] = i2ra_pkg::DIGIT_W'(quo % base);
                n++;
            end
            quo = quo / base;
        end while (quo != 0);
        for (int k = 0; k < n; k++) begin
            d = vals[n-1-k];
            if (d < 6'd10) begin
                e.ch = i2ra_pkg::ASCII_ZERO + {1'b0, d};
            end else begin
                e.ch = i2ra_pkg::ASCII_LC_A + {1'b0, d} - 7'd10;
            end
            e.minus = (k == 0) && neg;
            e.last  = (k == n - 1);
            digit_q.push_back(e);
        end
    endfunction

    function automatic void push_text(input string s, input bit minus);
        t_digit e;
        for (int k = 0; k < s.len(); k++) begin
            e.ch    = i2ra_pkg::CHAR_W'(s[k]);
            e.minus = (k == 0) && minus;
            e.last  = (k == s.len() - 1);
            digit_q.push_back(e);
        end
    endfunction

    function automatic void add_row(input bit wr, input logic [i2ra_pkg::RADIX_W-1:0] wr_val,
                                    input logic [i2ra_pkg::VALUE_W-1:0] value, input bit sgn,
                                    input string s, input bit minus);
        t_row r;
        r.wr     = wr;
        r.wr_val = wr_val;
        r.value  = value;
        r.sgn    = sgn;
        r.typed  = (s.len() > 0);
        r.minus  = minus;
        rows.push_back(r);
        row_text.push_back(s);
    endfunction

    function automatic logic [i2ra_pkg::VALUE_W-1:0] random_value();
        logic [i2ra_pkg::VALUE_W-1:0] v;
        case ($urandom_range(0, 5))
            0: v = {$urandom(), $urandom()};
            1: v = i2ra_pkg::VALUE_W'($urandom_range(0, 40));
            2: v = {$urandom(), $urandom()} >> $urandom_range(0, 63);
            3: v = ~i2ra_pkg::VALUE_W'($urandom_range(0, 99));
            4: begin
                case ($urandom_range(0, 3))
                    0: v = '0;
                    1: v = ALL_ONES;
                    2: v = MOST_NEG;
                    default: v = MOST_POS;
                endcase
            end
            default: v = {$urandom(), $urandom()};
        endcase
        return v;
    endfunction

    task automatic wait_drained();
        while (digit_q.size() != 0) begin
            @(posedge i_clk);
        end
    endtask

    task automatic write_radix(input logic [i2ra_pkg::RADIX_W-1:0] w);
        @(negedge i_clk);
        i_radix_we = 1'b1;
        i_radix    = w;
        @(posedge i_clk);
        if (w < i2ra_pkg::RADIX_MIN) begin
            radix_now = i2ra_pkg::RADIX_MIN;
        end else if (w > i2ra_pkg::RADIX_MAX) begin
            radix_now = i2ra_pkg::RADIX_MAX;
        end else begin
            radix_now = w;
        end
        n_radix_writes++;
        @(negedge i_clk);
        i_radix_we = 1'b0;
        i_radix    = i2ra_pkg::RADIX_W'($urandom());
    endtask

    task automatic send_request(input logic [i2ra_pkg::VALUE_W-1:0] value, input bit sgn,
                                input bit typed, input string s, input bit minus);
        @(negedge i_clk);
        if (!quiet && $urandom_range(0, 99) < 18) begin
            i_in_valid = 1'b0;
            repeat ($urandom_range(1, 4)) @(negedge i_clk);
        end
        i_in_valid  = 1'b1;
        i_value     = value;
        i_is_signed = sgn;
        do begin
            @(posedge i_clk);
        end while (o_in_stall);
        if (typed) begin
            push_text(s, minus);
        end else begin
            predict_digits(value, sgn);
        end
        n_requests++;
    endtask

    // Receiver: a requested hold-off takes priority over random stalls.
    always @(negedge i_clk) begin
        if (hold_left > 0) begin
            i_out_stall = 1'b1;
            hold_left   = hold_left - 1;
        end else begin
            i_out_stall = !quiet && ($urandom_range(0, 99) < 18);
        end
    end

    always @(posedge i_clk) begin
        t_digit e;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            n_digits++;
            if (digit_q.size() == 0) begin
                $display("%0t: unexpected digit: expected none, got char %h minus %b last %b",
                         $time, o_digit_char, o_minus_before, o_last_digit);
                n_errors++;
            end else begin
                e = digit_q.pop_front();
                if (o_digit_char !== e.ch) begin
                    $display("%0t: digit_char mismatch: expected %h, got %h",
                             $time, e.ch, o_digit_char);
                    n_errors++;
                end
                if (o_minus_before !== e.minus) begin
                    $display("%0t: minus_before mismatch: expected %b, got %b",
                             $time, e.minus, o_minus_before);
                    n_errors++;
                end
                if (o_last_digit !== e.last) begin
                    $display("%0t: last_digit mismatch: expected %b, got %b",
                             $time, e.last, o_last_digit);
                    n_errors++;
                end
            end
        end
    end

    initial begin
        #40_000_000;
        $display("simulation failed");
        $finish;
    end

    initial begin
        logic [i2ra_pkg::RADIX_W-1:0] phase_radix[6];
        i_rst_n        = 1'b0;
        i_radix_we     = 1'b0;
        i_radix        = '0;
        i_in_valid     = 1'b0;
        i_value        = '0;
        i_is_signed    = 1'b0;
        i_out_stall    = 1'b0;
        radix_now      = i2ra_pkg::RADIX_RESET;
        quiet          = 1'b0;
        hold_left      = 0;
        n_errors       = 0;
        n_requests     = 0;
        n_digits       = 0;
        n_radix_writes = 0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        add_row(0, 0, 64'd0, 0, "0", 0);
        add_row(0, 0, 64'd0, 1, "0", 0);
        add_row(0, 0, ALL_ONES, 0, "18446744073709551615", 0);
        add_row(0, 0, ALL_ONES, 1, "1", 1);
        add_row(0, 0, MOST_NEG, 1, "9223372036854775808", 1);
        add_row(0, 0, MOST_NEG, 0, "9223372036854775808", 0);
        add_row(0, 0, MOST_POS, 1, "9223372036854775807", 0);
        add_row(0, 0, 64'd9, 0, "9", 0);
        add_row(0, 0, 64'd10, 1, "10", 0);
        add_row(1, 6'd16, ALL_ONES, 0, "ffffffffffffffff", 0);
        add_row(0, 0, 64'hDEAD_BEEF_0123_4567, 1, "", 0);
        add_row(0, 0, MOST_NEG, 1, "8000000000000000", 1);
        add_row(1, 6'd0, 64'd5, 0, "101", 0);
        add_row(0, 0, ALL_ONES, 0, "", 0);
        add_row(0, 0, MOST_NEG, 1, "", 0);
        add_row(1, 6'd63, 64'd35, 0, "z", 0);
        add_row(0, 0, 64'd36, 0, "10", 0);
        add_row(0, 0, ALL_ONES, 0, "", 0);
        add_row(1, 6'd1, 64'd2, 0, "10", 0);
        add_row(1, 6'd37, 64'd71, 0, "1z", 0);
        add_row(1, 6'd36, 64'hFFFF_FFFF_FFFF_FFFE, 1, "2", 1);
        add_row(1, 6'd2, 64'd1, 1, "1", 0);

        for (int i = 0; i < rows.size(); i++) begin
            if (rows[i].wr) begin
                @(negedge i_clk);
                i_in_valid = 1'b0;
                wait_drained();
                write_radix(rows[i].wr_val);
            end
            send_request(rows[i].value, rows[i].sgn, rows[i].typed, row_text[i],
                         rows[i].minus);
        end

        phase_radix[0] = 6'd10;
        phase_radix[1] = 6'd36;
        phase_radix[2] = i2ra_pkg::RADIX_W'($urandom_range(0, 63));
        phase_radix[3] = 6'd16;
        phase_radix[4] = 6'd2;
        phase_radix[5] = i2ra_pkg::RADIX_W'($urandom_range(0, 63));
        for (int p = 0; p < 6; p++) begin
            @(negedge i_clk);
            i_in_valid = 1'b0;
            wait_drained();
            write_radix(phase_radix[p]);
            quiet = (p == 4);
            if (p == 2) begin
                hold_left = 600;
            end
            for (int j = 0; j < 42; j++) begin
                send_request(random_value(), 1'($urandom_range(0, 1)), 0, "", 0);
            end
        end
        quiet = 1'b0;
        @(negedge i_clk);
        i_in_valid = 1'b0;
        wait_drained();
        repeat (40) @(posedge i_clk);

        $display("Converted %0d requests into %0d digits over %0d radix settings.",
                 n_requests, n_digits, n_radix_writes + 1);
        $display("Bases 2, 10, 16, 36 and clamped writes were used, with stalls on both sides.");
        if (n_errors == 0 && digit_q.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
